### src/dsup_pkg.sv
// Shared types, codes, register defaults and transition tables of the dosing supervisor.
package dsup_pkg;

    localparam int CFG_W   = 20;
    localparam int ADDR_W  = 5;
    localparam int PDATA_W = 32;
    localparam int PIDX_W  = 2;
    localparam int PUMP_FIELDS = 4;

    localparam logic [CFG_W-1:0] SYS_ERR_REC_RST  = 20'd5000;
    localparam logic [CFG_W-1:0] PUMP_COOL_RST    = 20'd300000;
    localparam logic [CFG_W-1:0] PUMP_DOSE_RST    = 20'd600000;
    localparam logic [CFG_W-1:0] SNS_ERR_REC_RST  = 20'd10000;
    localparam logic [CFG_W-1:0] SNS_WARM_RST     = 20'd5000;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_SYS  = 3'd1,
        OP_PUMP = 3'd2,
        OP_SNS  = 3'd3,
        OP_CAL  = 3'd4,
        OP_STOP = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        REG_SYS_ERR_REC = 3'd0,
        REG_PUMP_COOL   = 3'd1,
        REG_PUMP_DOSE   = 3'd2,
        REG_SNS_ERR_REC = 3'd3,
        REG_SNS_WARM    = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        SYS_STARTUP  = 3'd0,
        SYS_INIT     = 3'd1,
        SYS_MONITOR  = 3'd2,
        SYS_DOSING   = 3'd3,
        SYS_CALIB    = 3'd4,
        SYS_ERROR    = 3'd5,
        SYS_MAINT    = 3'd6,
        SYS_SHUTDOWN = 3'd7
    } t_sys_state;

    typedef enum logic [2:0] {
        PMP_IDLE   = 3'd0,
        PMP_PRIME  = 3'd1,
        PMP_DOSING = 3'd2,
        PMP_COOL   = 3'd3,
        PMP_ERROR  = 3'd4,
        PMP_MAINT  = 3'd5
    } t_pump_state;

    typedef enum logic [2:0] {
        SNS_INIT   = 3'd0,
        SNS_WARM   = 3'd1,
        SNS_READ   = 3'd2,
        SNS_FILTER = 3'd3,
        SNS_READY  = 3'd4,
        SNS_ERROR  = 3'd5
    } t_sns_state;

    typedef struct packed {
        logic [CFG_W-1:0] sys_err_rec;
        logic [CFG_W-1:0] pump_cool;
        logic [CFG_W-1:0] pump_dose;
        logic [CFG_W-1:0] sns_err_rec;
        logic [CFG_W-1:0] sns_warm;
    } t_cfg;

    // One item as seen by the state units, with the update strobe.
    typedef struct packed {
        logic       fire;
        logic [2:0] op;
        logic [2:0] tgt;
    } t_step;

    typedef struct packed {
        logic       fire;
        logic       tick;
        logic       stop;
        logic       req;
        logic       sys_maint;
        logic [2:0] tgt;
    } t_pump_ctl;

    function automatic logic sys_ok(t_sys_state cur, logic [2:0] tgt);
        logic ok;
        ok = 1'b0;
        if (tgt == SYS_ERROR || tgt == SYS_MAINT || tgt == SYS_SHUTDOWN) begin
            ok = 1'b1;
        end else begin
            case (cur)
                SYS_STARTUP:  ok = (tgt == SYS_INIT);
                SYS_INIT:     ok = (tgt == SYS_MONITOR);
                SYS_MONITOR:  ok = (tgt == SYS_DOSING) || (tgt == SYS_CALIB);
                SYS_DOSING:   ok = (tgt == SYS_MONITOR);
                SYS_CALIB:    ok = (tgt == SYS_MONITOR);
                SYS_ERROR:    ok = (tgt == SYS_MONITOR) || (tgt == SYS_INIT);
                SYS_MAINT:    ok = (tgt == SYS_MONITOR);
                SYS_SHUTDOWN: ok = (tgt == SYS_STARTUP);
                default:      ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    function automatic logic pump_ok(t_pump_state cur, logic [2:0] tgt);
        logic ok;
        ok = 1'b0;
        if (tgt > PMP_MAINT) begin
            ok = 1'b0;
        end else if (tgt == PMP_IDLE || tgt == PMP_ERROR || tgt == PMP_MAINT) begin
            ok = 1'b1;
        end else begin
            case (cur)
                PMP_IDLE:   ok = (tgt == PMP_PRIME);
                PMP_PRIME:  ok = (tgt == PMP_DOSING);
                PMP_DOSING: ok = (tgt == PMP_COOL);
                default:    ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    function automatic logic sns_ok(t_sns_state cur, logic [2:0] tgt);
        logic ok;
        ok = 1'b0;
        if (tgt > SNS_ERROR) begin
            ok = 1'b0;
        end else if (tgt == SNS_ERROR) begin
            ok = 1'b1;
        end else begin
            case (cur)
                SNS_INIT:   ok = (tgt == SNS_READY);
                SNS_WARM:   ok = (tgt == SNS_READ);
                SNS_READ:   ok = (tgt == SNS_FILTER);
                SNS_FILTER: ok = (tgt == SNS_READY);
                SNS_READY:  ok = (tgt == SNS_WARM);
                SNS_ERROR:  ok = (tgt == SNS_INIT) || (tgt == SNS_READY);
                default:    ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

endpackage

### src/dosing_supervisor_fsm.sv
// Each item waits in the input register; its result is held in the result register.
// One item per cycle while results are taken; all checks and counter updates sit between them.
// The input register takes a new item whenever it is empty or its item moves on to the result.
// Reset (synchronous, active low): system startup, sensor init, calibration idle, all pumps idle,
// all elapsed counters zero, limit registers at their defaults, both stages empty.
// Top level of the dosing supervisor.
module dosing_supervisor_fsm #(
    parameter int NUM_PUMPS    = 4,
    parameter int ELAPSED_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_op,
    input  logic [2:0]                      i_target_state,
    input  logic [1:0]                      i_pump_sel,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_accepted,
    output logic [2:0]                      o_system_now,
    output logic [2:0]                      o_sensor_now,
    output logic                            o_calibration_now,
    output logic [2:0]                      o_pump0_now,
    output logic [2:0]                      o_pump1_now,
    output logic [2:0]                      o_pump2_now,
    output logic [2:0]                      o_pump3_now,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dsup_pkg::ADDR_W-1:0]     paddr,
    input  logic [dsup_pkg::PDATA_W-1:0]    pwdata,
    output logic [dsup_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    logic       r_in_vld;
    logic [2:0] r_op, r_tgt;
    logic [1:0] r_pidx;
    logic       r_out_vld;
    logic       r_acc, r_cal;
    logic [2:0] r_sys, r_sns;
    logic [2:0] r_pump [dsup_pkg::PUMP_FIELDS];

    logic                   w_fire;
    dsup_pkg::t_cfg         w_cfg;
    dsup_pkg::t_step        w_step;
    dsup_pkg::t_sys_state   w_sys_cur, w_sys_next;
    dsup_pkg::t_sns_state   w_sns_next;
    logic                   w_cal_next, w_acc;
    logic [NUM_PUMPS-1:0]   w_pump_acc;
    dsup_pkg::t_pump_state  w_pump_next [NUM_PUMPS];
    logic [2:0]             w_pump_out  [dsup_pkg::PUMP_FIELDS];

    assign w_fire     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= i_op;
            r_tgt  <= i_target_state;
            r_pidx <= i_pump_sel;
        end
    end

    assign w_step.fire = w_fire;
    assign w_step.op   = r_op;
    assign w_step.tgt  = r_tgt;

    dsup_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dsup_main #(.ELAPSED_BITS(ELAPSED_BITS)) u_main (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_cfg      (w_cfg),
        .i_pump_acc (|w_pump_acc),
        .o_sys_cur  (w_sys_cur),
        .o_sys_next (w_sys_next),
        .o_sns_next (w_sns_next),
        .o_cal_next (w_cal_next),
        .o_acc      (w_acc)
    );

    for (genvar i = 0; i < NUM_PUMPS; i++) begin : g_pump
        dsup_pkg::t_pump_ctl w_ctl;
        logic                w_hit;

        // Only the first four pumps can be addressed by the index field.
        if (i < dsup_pkg::PUMP_FIELDS) begin : g_addr
            assign w_hit = (r_pidx == dsup_pkg::PIDX_W'(i));
        end else begin : g_noaddr
            assign w_hit = 1'b0;
        end

        assign w_ctl.fire      = w_fire;
        assign w_ctl.tick      = (r_op == dsup_pkg::OP_TICK);
        assign w_ctl.stop      = (r_op == dsup_pkg::OP_STOP);
        assign w_ctl.req       = (r_op == dsup_pkg::OP_PUMP) && w_hit;
        assign w_ctl.sys_maint = (w_sys_cur == dsup_pkg::SYS_MAINT);
        assign w_ctl.tgt       = r_tgt;

        dsup_pump #(.ELAPSED_BITS(ELAPSED_BITS)) u_pump (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_cool_ms (w_cfg.pump_cool),
            .i_dose_ms (w_cfg.pump_dose),
            .o_next    (w_pump_next[i]),
            .o_acc     (w_pump_acc[i])
        );
    end

    for (genvar k = 0; k < dsup_pkg::PUMP_FIELDS; k++) begin : g_field
        if (k < NUM_PUMPS) begin : g_live
            assign w_pump_out[k] = w_pump_next[k];
        end else begin : g_absent
            assign w_pump_out[k] = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_acc <= w_acc;
            r_sys <= w_sys_next;
            r_sns <= w_sns_next;
            r_cal <= w_cal_next;
            for (int k = 0; k < dsup_pkg::PUMP_FIELDS; k++) begin
                r_pump[k] <= w_pump_out[k];
            end
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_accepted        = r_acc;
    assign o_system_now      = r_sys;
    assign o_sensor_now      = r_sns;
    assign o_calibration_now = r_cal;
    assign o_pump0_now       = r_pump[0];
    assign o_pump1_now       = r_pump[1];
    assign o_pump2_now       = r_pump[2];
    assign o_pump3_now       = r_pump[3];

    // An emergency stop always lands the system in error and the sensor in ready.
    a_stop_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_op == dsup_pkg::OP_STOP |=>
            o_accepted && o_system_now == dsup_pkg::SYS_ERROR
            && o_sensor_now == dsup_pkg::SNS_READY)
        else $error("emergency stop did not force safe states");

    // Ticks are always accepted.
    a_tick_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_op == dsup_pkg::OP_TICK |=> o_accepted)
        else $error("tick reported as rejected");

    // Unknown operations are rejected and leave the system machine alone.
    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_op > dsup_pkg::OP_STOP |=>
            !o_accepted && o_system_now == $past(w_sys_cur))
        else $error("unknown operation changed state or was accepted");

    // A result waiting for the consumer is overwritten only when it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> !r_out_vld || i_out_ready)
        else $error("result register overwritten while stalled");

endmodule

### src/dsup_apb_regs.sv
// APB register file holding the five timeout limits.
module dsup_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dsup_pkg::ADDR_W-1:0]     paddr,
    input  logic [dsup_pkg::PDATA_W-1:0]    pwdata,
    output logic [dsup_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output dsup_pkg::t_cfg                  o_cfg
);

    dsup_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx  = paddr[dsup_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sys_err_rec <= dsup_pkg::SYS_ERR_REC_RST;
            r_cfg.pump_cool   <= dsup_pkg::PUMP_COOL_RST;
            r_cfg.pump_dose   <= dsup_pkg::PUMP_DOSE_RST;
            r_cfg.sns_err_rec <= dsup_pkg::SNS_ERR_REC_RST;
            r_cfg.sns_warm    <= dsup_pkg::SNS_WARM_RST;
        end else if (w_wr) begin
            case (dsup_pkg::t_reg_idx'(w_idx))
                dsup_pkg::REG_SYS_ERR_REC: r_cfg.sys_err_rec <= pwdata[dsup_pkg::CFG_W-1:0];
                dsup_pkg::REG_PUMP_COOL:   r_cfg.pump_cool   <= pwdata[dsup_pkg::CFG_W-1:0];
                dsup_pkg::REG_PUMP_DOSE:   r_cfg.pump_dose   <= pwdata[dsup_pkg::CFG_W-1:0];
                dsup_pkg::REG_SNS_ERR_REC: r_cfg.sns_err_rec <= pwdata[dsup_pkg::CFG_W-1:0];
                dsup_pkg::REG_SNS_WARM:    r_cfg.sns_warm    <= pwdata[dsup_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (dsup_pkg::t_reg_idx'(w_idx))
            dsup_pkg::REG_SYS_ERR_REC: prdata = dsup_pkg::PDATA_W'(r_cfg.sys_err_rec);
            dsup_pkg::REG_PUMP_COOL:   prdata = dsup_pkg::PDATA_W'(r_cfg.pump_cool);
            dsup_pkg::REG_PUMP_DOSE:   prdata = dsup_pkg::PDATA_W'(r_cfg.pump_dose);
            dsup_pkg::REG_SNS_ERR_REC: prdata = dsup_pkg::PDATA_W'(r_cfg.sns_err_rec);
            dsup_pkg::REG_SNS_WARM:    prdata = dsup_pkg::PDATA_W'(r_cfg.sns_warm);
            default:                   prdata = '0;
        endcase
    end

endmodule

### src/dsup_pump.sv
// One pump state machine with its saturating elapsed counter.
module dsup_pump #(
    parameter int ELAPSED_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dsup_pkg::t_pump_ctl             i_ctl,
    input  logic [dsup_pkg::CFG_W-1:0]      i_cool_ms,
    input  logic [dsup_pkg::CFG_W-1:0]      i_dose_ms,
    output dsup_pkg::t_pump_state           o_next,
    output logic                            o_acc
);

    localparam int CMP_W = (ELAPSED_BITS > dsup_pkg::CFG_W) ? ELAPSED_BITS : dsup_pkg::CFG_W;

    dsup_pkg::t_pump_state r_mode, n_mode;
    logic [ELAPSED_BITS-1:0] r_el, n_el, w_bump;

    assign w_bump = (&r_el) ? r_el : r_el + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dsup_pkg::PMP_IDLE;
            r_el   <= '0;
        end else if (i_ctl.fire) begin
            r_mode <= n_mode;
            r_el   <= n_el;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_el   = r_el;
        o_acc  = 1'b0;
        if (i_ctl.tick) begin
            n_el = w_bump;
            // Maintenance of the system pulls every busy pump into maintenance.
            if (i_ctl.sys_maint && r_mode != dsup_pkg::PMP_MAINT
                    && r_mode != dsup_pkg::PMP_IDLE) begin
                n_mode = dsup_pkg::PMP_MAINT;
                n_el   = '0;
            end else if (r_mode == dsup_pkg::PMP_COOL
                    && CMP_W'(w_bump) > CMP_W'(i_cool_ms)) begin
                n_mode = dsup_pkg::PMP_IDLE;
                n_el   = '0;
            end else if (r_mode == dsup_pkg::PMP_DOSING
                    && CMP_W'(w_bump) > CMP_W'(i_dose_ms)) begin
                n_mode = dsup_pkg::PMP_ERROR;
                n_el   = '0;
            end
        end else if (i_ctl.stop) begin
            n_mode = dsup_pkg::PMP_IDLE;
            n_el   = '0;
        end else if (i_ctl.req && dsup_pkg::pump_ok(r_mode, i_ctl.tgt)) begin
            n_mode = dsup_pkg::t_pump_state'(i_ctl.tgt);
            n_el   = '0;
            o_acc  = 1'b1;
        end
    end

    assign o_next = n_mode;

endmodule

### src/dsup_main.sv
// System machine, sensor machine and calibration flag with their counters.
module dsup_main #(
    parameter int ELAPSED_BITS = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dsup_pkg::t_step         i_step,
    input  dsup_pkg::t_cfg          i_cfg,
    input  logic                    i_pump_acc,
    output dsup_pkg::t_sys_state    o_sys_cur,
    output dsup_pkg::t_sys_state    o_sys_next,
    output dsup_pkg::t_sns_state    o_sns_next,
    output logic                    o_cal_next,
    output logic                    o_acc
);

    localparam int CMP_W = (ELAPSED_BITS > dsup_pkg::CFG_W) ? ELAPSED_BITS : dsup_pkg::CFG_W;

    dsup_pkg::t_sys_state r_sys, n_sys;
    dsup_pkg::t_sns_state r_sns, n_sns;
    logic r_cal, n_cal;
    logic [ELAPSED_BITS-1:0] r_sys_el, n_sys_el, r_sns_el, n_sns_el;
    logic [ELAPSED_BITS-1:0] w_sys_bump, w_sns_bump;

    assign w_sys_bump = (&r_sys_el) ? r_sys_el : r_sys_el + 1'b1;
    assign w_sns_bump = (&r_sns_el) ? r_sns_el : r_sns_el + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys    <= dsup_pkg::SYS_STARTUP;
            r_sns    <= dsup_pkg::SNS_INIT;
            r_cal    <= 1'b0;
            r_sys_el <= '0;
            r_sns_el <= '0;
        end else if (i_step.fire) begin
            r_sys    <= n_sys;
            r_sns    <= n_sns;
            r_cal    <= n_cal;
            r_sys_el <= n_sys_el;
            r_sns_el <= n_sns_el;
        end
    end

    always_comb begin
        n_sys    = r_sys;
        n_sns    = r_sns;
        n_cal    = r_cal;
        n_sys_el = r_sys_el;
        n_sns_el = r_sns_el;
        o_acc    = 1'b0;
        case (dsup_pkg::t_op'(i_step.op))
            dsup_pkg::OP_TICK: begin
                o_acc    = 1'b1;
                n_sys_el = w_sys_bump;
                n_sns_el = w_sns_bump;
                if (r_sys == dsup_pkg::SYS_ERROR
                        && CMP_W'(w_sys_bump) > CMP_W'(i_cfg.sys_err_rec)) begin
                    n_sys    = dsup_pkg::SYS_MONITOR;
                    n_sys_el = '0;
                end
                if (r_sns == dsup_pkg::SNS_ERROR
                        && CMP_W'(w_sns_bump) > CMP_W'(i_cfg.sns_err_rec)) begin
                    n_sns    = dsup_pkg::SNS_READY;
                    n_sns_el = '0;
                end else if (r_sns == dsup_pkg::SNS_WARM
                        && CMP_W'(w_sns_bump) > CMP_W'(i_cfg.sns_warm)) begin
                    n_sns    = dsup_pkg::SNS_ERROR;
                    n_sns_el = '0;
                end
            end
            dsup_pkg::OP_SYS: begin
                if (dsup_pkg::sys_ok(r_sys, i_step.tgt)) begin
                    n_sys    = dsup_pkg::t_sys_state'(i_step.tgt);
                    n_sys_el = '0;
                    o_acc    = 1'b1;
                end
            end
            dsup_pkg::OP_PUMP: o_acc = i_pump_acc;
            dsup_pkg::OP_SNS: begin
                if (dsup_pkg::sns_ok(r_sns, i_step.tgt)) begin
                    n_sns    = dsup_pkg::t_sns_state'(i_step.tgt);
                    n_sns_el = '0;
                    o_acc    = 1'b1;
                end
            end
            dsup_pkg::OP_CAL: begin
                if (i_step.tgt[2:1] == 2'b00) begin
                    n_cal = i_step.tgt[0];
                    o_acc = 1'b1;
                end
            end
            dsup_pkg::OP_STOP: begin
                o_acc    = 1'b1;
                n_sys    = dsup_pkg::SYS_ERROR;
                n_sys_el = '0;
                n_sns    = dsup_pkg::SNS_READY;
                n_sns_el = '0;
            end
            default: ;
        endcase
    end

    assign o_sys_cur  = r_sys;
    assign o_sys_next = n_sys;
    assign o_sns_next = n_sns;
    assign o_cal_next = n_cal;

endmodule

### tb/dosing_supervisor_checker.sv
// Watches the dosing supervisor channels, predicts every status result and compares it.
`timescale 1ns / 1ps

module dosing_supervisor_checker #(
    parameter int NUM_PUMPS    = 4,
    parameter int ELAPSED_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [2:0]                      i_op,
    input  logic [2:0]                      i_target_state,
    input  logic [1:0]                      i_pump_sel,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_accepted,
    input  logic [2:0]                      i_system_now,
    input  logic [2:0]                      i_sensor_now,
    input  logic                            i_calibration_now,
    input  logic [2:0]                      i_pump0_now,
    input  logic [2:0]                      i_pump1_now,
    input  logic [2:0]                      i_pump2_now,
    input  logic [2:0]                      i_pump3_now,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [dsup_pkg::ADDR_W-1:0]     i_paddr,
    input  logic [dsup_pkg::PDATA_W-1:0]    i_pwdata,
    input  logic                            i_pready,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results
);
    import dsup_pkg::*;

    localparam logic [ELAPSED_BITS-1:0] MS_CEILING = '1;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic       acc;
        logic [2:0] sys;
        logic [2:0] sns;
        logic       cal;
        logic [2:0] p0;
        logic [2:0] p1;
        logic [2:0] p2;
        logic [2:0] p3;
    } t_status;

    logic [2:0]              sys_mode;
    logic [2:0]              sns_mode;
    logic                    cal_mode;
    logic [2:0]              pump_mode [NUM_PUMPS];
    logic [ELAPSED_BITS-1:0] sys_ms;
    logic [ELAPSED_BITS-1:0] sns_ms;
    logic [ELAPSED_BITS-1:0] pump_ms [NUM_PUMPS];
    logic [CFG_W-1:0]        lim_sys_rec;
    logic [CFG_W-1:0]        lim_cool;
    logic [CFG_W-1:0]        lim_dose;
    logic [CFG_W-1:0]        lim_sns_rec;
    logic [CFG_W-1:0]        lim_warm;
    t_status                 status_due_q [$];

    function automatic logic sys_move_ok(input logic [2:0] from, input logic [2:0] to);
        // Error, maintenance and shutdown are reachable from anywhere.
        if (to == SYS_ERROR || to == SYS_MAINT || to == SYS_SHUTDOWN) return 1'b1;
        case (from)
            SYS_STARTUP:  return to == SYS_INIT;
            SYS_INIT:     return to == SYS_MONITOR;
            SYS_MONITOR:  return to == SYS_DOSING || to == SYS_CALIB;
            SYS_DOSING:   return to == SYS_MONITOR;
            SYS_CALIB:    return to == SYS_MONITOR;
            SYS_ERROR:    return to == SYS_MONITOR || to == SYS_INIT;
            SYS_MAINT:    return to == SYS_MONITOR;
            SYS_SHUTDOWN: return to == SYS_STARTUP;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic logic pump_move_ok(input logic [2:0] from, input logic [2:0] to);
        if (to > PMP_MAINT) return 1'b0;
        if (to == PMP_IDLE || to == PMP_ERROR || to == PMP_MAINT) return 1'b1;
        case (from)
            PMP_IDLE:   return to == PMP_PRIME;
            PMP_PRIME:  return to == PMP_DOSING;
            PMP_DOSING: return to == PMP_COOL;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic logic sns_move_ok(input logic [2:0] from, input logic [2:0] to);
        if (to > SNS_ERROR) return 1'b0;
        if (to == SNS_ERROR) return 1'b1;
        case (from)
            SNS_INIT:   return to == SNS_READY;
            SNS_WARM:   return to == SNS_READ;
            SNS_READ:   return to == SNS_FILTER;
            SNS_FILTER: return to == SNS_READY;
            SNS_READY:  return to == SNS_WARM;
            SNS_ERROR:  return to == SNS_INIT || to == SNS_READY;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic logic [ELAPSED_BITS-1:0] bump_ms(input logic [ELAPSED_BITS-1:0] ms);
        return (ms == MS_CEILING) ? ms : ms + 1'b1;
    endfunction

    function automatic logic [2:0] pump_shown(input int idx);
        return (idx < NUM_PUMPS) ? pump_mode[idx] : 3'd0;
    endfunction

    task automatic reset_model();
        sys_mode    = SYS_STARTUP;
        sns_mode    = SNS_INIT;
        cal_mode    = 1'b0;
        sys_ms      = '0;
        sns_ms      = '0;
        lim_sys_rec = SYS_ERR_REC_RST;
        lim_cool    = PUMP_COOL_RST;
        lim_dose    = PUMP_DOSE_RST;
        lim_sns_rec = SNS_ERR_REC_RST;
        lim_warm    = SNS_WARM_RST;
        for (int i = 0; i < NUM_PUMPS; i++) begin
            pump_mode[i] = PMP_IDLE;
            pump_ms[i]   = '0;
        end
    endtask

    // One millisecond: all counters advance, then the timeout rules run in order.
    task automatic run_tick();
        logic [2:0] sns_was;
        sys_ms = bump_ms(sys_ms);
        sns_ms = bump_ms(sns_ms);
        for (int i = 0; i < NUM_PUMPS; i++) pump_ms[i] = bump_ms(pump_ms[i]);

        if (sys_mode == SYS_ERROR && sys_ms > lim_sys_rec) begin
            sys_mode = SYS_MONITOR;
            sys_ms   = '0;
        end
        if (sys_mode == SYS_MAINT) begin
            for (int i = 0; i < NUM_PUMPS; i++) begin
                if (pump_mode[i] != PMP_MAINT && pump_mode[i] != PMP_IDLE) begin
                    pump_mode[i] = PMP_MAINT;
                    pump_ms[i]   = '0;
                end
            end
        end
        for (int i = 0; i < NUM_PUMPS; i++) begin
            if (pump_mode[i] == PMP_COOL && pump_ms[i] > lim_cool) begin
                pump_mode[i] = PMP_IDLE;
                pump_ms[i]   = '0;
            end
            if (pump_mode[i] == PMP_DOSING && pump_ms[i] > lim_dose) begin
                pump_mode[i] = PMP_ERROR;
                pump_ms[i]   = '0;
            end
        end
        // The sensor rules look at the state from before either of them fired.
        sns_was = sns_mode;
        if (sns_was == SNS_ERROR && sns_ms > lim_sns_rec) begin
            sns_mode = SNS_READY;
            sns_ms   = '0;
        end else if (sns_was == SNS_WARM && sns_ms > lim_warm) begin
            sns_mode = SNS_ERROR;
            sns_ms   = '0;
        end
    endtask

    task automatic advance_supervisor(input logic [2:0] op, input logic [2:0] tgt,
                                      input logic [1:0] pidx, output t_status st);
        logic ok;
        ok = 1'b0;
        case (op)
            OP_TICK: begin
                run_tick();
                ok = 1'b1;
            end
            OP_SYS: begin
                if (sys_move_ok(sys_mode, tgt)) begin
                    sys_mode = tgt;
                    sys_ms   = '0;
                    ok       = 1'b1;
                end
            end
            OP_PUMP: begin
                if (int'(pidx) < NUM_PUMPS) begin
                    if (pump_move_ok(pump_mode[pidx], tgt)) begin
                        pump_mode[pidx] = tgt;
                        pump_ms[pidx]   = '0;
                        ok              = 1'b1;
                    end
                end
            end
            OP_SNS: begin
                if (sns_move_ok(sns_mode, tgt)) begin
                    sns_mode = tgt;
                    sns_ms   = '0;
                    ok       = 1'b1;
                end
            end
            OP_CAL: begin
                if (tgt <= 3'd1) begin
                    cal_mode = tgt[0];
                    ok       = 1'b1;
                end
            end
            OP_STOP: begin
                sys_mode = SYS_ERROR;
                sys_ms   = '0;
                for (int i = 0; i < NUM_PUMPS; i++) begin
                    pump_mode[i] = PMP_IDLE;
                    pump_ms[i]   = '0;
                end
                sns_mode = SNS_READY;
                sns_ms   = '0;
                ok       = 1'b1;
            end
            default: ok = 1'b0;
        endcase
        st.acc = ok;
        st.sys = sys_mode;
        st.sns = sns_mode;
        st.cal = cal_mode;
        st.p0  = pump_shown(0);
        st.p1  = pump_shown(1);
        st.p2  = pump_shown(2);
        st.p3  = pump_shown(3);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            o_errors++;
            if (o_errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_status got;
        t_status want;
        t_status nxt;
        if (!i_rst_n) begin
            reset_model();
            status_due_q.delete();
            o_errors  = 0;
            o_results = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_SYS_ERR_REC: lim_sys_rec = i_pwdata[CFG_W-1:0];
                    REG_PUMP_COOL:   lim_cool    = i_pwdata[CFG_W-1:0];
                    REG_PUMP_DOSE:   lim_dose    = i_pwdata[CFG_W-1:0];
                    REG_SNS_ERR_REC: lim_sns_rec = i_pwdata[CFG_W-1:0];
                    REG_SNS_WARM:    lim_warm    = i_pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.acc = i_accepted;
                got.sys = i_system_now;
                got.sns = i_sensor_now;
                got.cal = i_calibration_now;
                got.p0  = i_pump0_now;
                got.p1  = i_pump1_now;
                got.p2  = i_pump2_now;
                got.p3  = i_pump3_now;
                o_results++;
                if (status_due_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, got);
                end else begin
                    want = status_due_q.pop_front();
                    check_field("accepted", want.acc, got.acc);
                    check_field("system_now", want.sys, got.sys);
                    check_field("sensor_now", want.sns, got.sns);
                    check_field("calibration_now", want.cal, got.cal);
                    check_field("pump0_now", want.p0, got.p0);
                    check_field("pump1_now", want.p1, got.p1);
                    check_field("pump2_now", want.p2, got.p2);
                    check_field("pump3_now", want.p3, got.p3);
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_supervisor(i_op, i_target_state, i_pump_sel, nxt);
                status_due_q.push_back(nxt);
            end
        end
        o_pending = status_due_q.size();
    end

endmodule

### tb/tb_dosing_supervisor_fsm.sv
// Stimulus and verdict for the dosing supervisor, checked by a separate checker module.
`timescale 1ns / 1ps

module tb_dosing_supervisor_fsm;
    import dsup_pkg::*;

    localparam int N_PUMPS      = 4;
    localparam int ELAPSED_W    = 20;
    localparam int RANDOM_ITEMS = 1700;
    localparam int N_PHASES     = 8;

    // Op codes the block does not know; it answers them without a state change.
    localparam logic [2:0] OP_UNUSED_A = 3'd6;
    localparam logic [2:0] OP_UNUSED_B = 3'd7;
    localparam logic [2:0] TGT_PAST_MACHINE = 3'd6;
    localparam logic [2:0] TGT_ALL_ONES     = 3'd7;
    localparam logic [2:0] CAL_IDLE   = 3'd0;
    localparam logic [2:0] CAL_ACTIVE = 3'd1;
    localparam logic [2:0] CAL_BEYOND = 3'd2;
    localparam logic [CFG_W-1:0] LIM_TOP = 20'd1048574;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [2:0]          op = '0;
    logic [2:0]          target_state = '0;
    logic [1:0]          pump_sel = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                accepted;
    logic [2:0]          system_now;
    logic [2:0]          sensor_now;
    logic                calibration_now;
    logic [2:0]          pump0_now;
    logic [2:0]          pump1_now;
    logic [2:0]          pump2_now;
    logic [2:0]          pump3_now;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int chk_errors;
    int chk_pending;
    int chk_results;
    int sent_items = 0;
    int directed_items = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    always #1 clk = ~clk;

    dosing_supervisor_fsm #(
        .NUM_PUMPS    (N_PUMPS),
        .ELAPSED_BITS (ELAPSED_W)
    ) i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_op              (op),
        .i_target_state    (target_state),
        .i_pump_sel        (pump_sel),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_accepted        (accepted),
        .o_system_now      (system_now),
        .o_sensor_now      (sensor_now),
        .o_calibration_now (calibration_now),
        .o_pump0_now       (pump0_now),
        .o_pump1_now       (pump1_now),
        .o_pump2_now       (pump2_now),
        .o_pump3_now       (pump3_now),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    dosing_supervisor_checker #(
        .NUM_PUMPS    (N_PUMPS),
        .ELAPSED_BITS (ELAPSED_W)
    ) i_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_op              (op),
        .i_target_state    (target_state),
        .i_pump_sel        (pump_sel),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_accepted        (accepted),
        .i_system_now      (system_now),
        .i_sensor_now      (sensor_now),
        .i_calibration_now (calibration_now),
        .i_pump0_now       (pump0_now),
        .i_pump1_now       (pump1_now),
        .i_pump2_now       (pump2_now),
        .i_pump3_now       (pump3_now),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_errors          (chk_errors),
        .o_pending         (chk_pending),
        .o_results         (chk_results)
    );

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [2:0] rand_code(input int unsigned lo, input int unsigned hi);
        return 3'($urandom_range(lo, hi));
    endfunction

    function automatic logic [1:0] rand_pump();
        return 2'($urandom_range(0, 3));
    endfunction

    // Called at a falling edge; returns at the falling edge after the item was taken,
    // with valid still high so that the next call can follow without a bubble.
    task automatic push_item(input logic [2:0] i_op_c, input logic [2:0] tgt,
                             input logic [1:0] pidx);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        op           <= i_op_c;
        target_state <= tgt;
        pump_sel     <= pidx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (i_op_c != OP_UNUSED_A && i_op_c != OP_UNUSED_B) sent_items++;
    endtask

    task automatic tick_run(input int n);
        repeat (n) push_item(OP_TICK, rand_code(0, 7), rand_pump());
    endtask

    function automatic int pick_ticks();
        if ($urandom_range(0, 3) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 8);
    endfunction

    // Lets every outstanding status come back with the sender held off.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(PDATA_W-CFG_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_limit(input int phase);
        int r;
        if (phase == 0) return '0;
        if (phase == 1) return LIM_TOP;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return LIM_TOP;
        return CFG_W'($urandom_range(1, 25));
    endfunction

    task automatic set_limits(input int phase);
        write_reg(REG_SYS_ERR_REC, pick_limit(phase));
        write_reg(REG_PUMP_COOL, pick_limit(phase));
        write_reg(REG_PUMP_DOSE, pick_limit(phase));
        write_reg(REG_SNS_ERR_REC, pick_limit(phase));
        write_reg(REG_SNS_WARM, pick_limit(phase));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic system_walk();
        case ($urandom_range(0, 4))
            0: begin
                push_item(OP_SYS, SYS_INIT, rand_pump());
                tick_run(pick_ticks());
                push_item(OP_SYS, SYS_MONITOR, rand_pump());
                tick_run(pick_ticks());
                push_item(OP_SYS, $urandom_range(0, 1) ? SYS_DOSING : SYS_CALIB,
                          rand_pump());
                tick_run(pick_ticks());
                push_item(OP_SYS, SYS_MONITOR, rand_pump());
            end
            1: begin
                push_item(OP_SYS, SYS_MAINT, rand_pump());
                tick_run(pick_ticks());
                push_item(OP_SYS, SYS_MONITOR, rand_pump());
            end
            2: begin
                push_item(OP_SYS, SYS_ERROR, rand_pump());
                tick_run(pick_ticks());
                push_item(OP_SYS, $urandom_range(0, 1) ? SYS_INIT : SYS_MONITOR,
                          rand_pump());
            end
            3: begin
                push_item(OP_SYS, SYS_SHUTDOWN, rand_pump());
                tick_run(pick_ticks());
                push_item(OP_SYS, SYS_STARTUP, rand_pump());
                push_item(OP_SYS, SYS_INIT, rand_pump());
            end
            default: begin
                push_item(OP_STOP, rand_code(0, 7), rand_pump());
                tick_run(pick_ticks());
            end
        endcase
    endtask

    task automatic pump_walk(input logic [1:0] pidx);
        if ($urandom_range(0, 2) == 0) push_item(OP_PUMP, PMP_IDLE, pidx);
        push_item(OP_PUMP, PMP_PRIME, pidx);
        tick_run($urandom_range(0, 3));
        push_item(OP_PUMP, PMP_DOSING, pidx);
        tick_run(pick_ticks());
        case ($urandom_range(0, 3))
            0: begin
                push_item(OP_PUMP, PMP_COOL, pidx);
                tick_run(pick_ticks());
            end
            1: tick_run(pick_ticks());
            2: begin
                push_item(OP_PUMP, PMP_ERROR, pidx);
                tick_run($urandom_range(0, 3));
                push_item(OP_PUMP, PMP_IDLE, pidx);
            end
            default: push_item(OP_PUMP, PMP_MAINT, pidx);
        endcase
    endtask

    task automatic sensor_walk();
        case ($urandom_range(0, 2))
            0: begin
                push_item(OP_SNS, SNS_READY, rand_pump());
                push_item(OP_SNS, SNS_WARM, rand_pump());
                tick_run(pick_ticks());
                push_item(OP_SNS, SNS_READ, rand_pump());
                push_item(OP_SNS, SNS_FILTER, rand_pump());
                push_item(OP_SNS, SNS_READY, rand_pump());
            end
            1: begin
                push_item(OP_SNS, SNS_ERROR, rand_pump());
                tick_run(pick_ticks());
                push_item(OP_SNS, $urandom_range(0, 1) ? SNS_INIT : SNS_READY,
                          rand_pump());
            end
            default: begin
                push_item(OP_SNS, SNS_WARM, rand_pump());
                tick_run(pick_ticks());
            end
        endcase
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4))
            push_item(rand_code(0, 7), rand_code(0, 7), rand_pump());
    endtask

    // The receiver stalls on its own schedule.
    initial begin
        int gap;
        forever begin
            @(negedge clk);
            gap = pick_gap(rx_calm);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("tb_dosing_supervisor_fsm: FAIL");
        $finish;
    end

    initial begin
        int quota;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, at the reset limits.
        push_item(OP_UNUSED_A, TGT_ALL_ONES, 2'd3);
        push_item(OP_UNUSED_B, SYS_STARTUP, 2'd0);
        push_item(OP_SYS, SYS_INIT, 2'd0);
        push_item(OP_SYS, SYS_MONITOR, 2'd1);
        push_item(OP_PUMP, PMP_PRIME, 2'd0);
        push_item(OP_PUMP, PMP_DOSING, 2'd0);
        push_item(OP_PUMP, TGT_PAST_MACHINE, 2'd3);
        push_item(OP_PUMP, TGT_ALL_ONES, 2'd1);
        push_item(OP_PUMP, PMP_COOL, 2'd2);
        push_item(OP_SNS, TGT_PAST_MACHINE, 2'd0);
        push_item(OP_SNS, SNS_READY, 2'd0);
        push_item(OP_SNS, TGT_ALL_ONES, 2'd0);
        push_item(OP_CAL, CAL_ACTIVE, 2'd0);
        push_item(OP_CAL, CAL_ACTIVE, 2'd0);
        push_item(OP_CAL, CAL_BEYOND, 2'd0);
        push_item(OP_CAL, TGT_ALL_ONES, 2'd0);
        push_item(OP_TICK, TGT_ALL_ONES, 2'd3);
        push_item(OP_SYS, SYS_MAINT, 2'd0);
        // Maintenance pulls the dosing pump into maintenance on this tick.
        push_item(OP_TICK, SYS_STARTUP, 2'd0);
        push_item(OP_STOP, SYS_STARTUP, 2'd0);
        push_item(OP_CAL, CAL_IDLE, 2'd0);
        push_item(OP_SYS, SYS_SHUTDOWN, 2'd0);
        push_item(OP_SYS, SYS_STARTUP, 2'd0);
        push_item(OP_PUMP, PMP_MAINT, 2'd3);
        push_item(OP_TICK, SYS_STARTUP, 2'd0);
        directed_items = sent_items;

        quota = RANDOM_ITEMS / N_PHASES;
        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain_block();
            set_limits(phase);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            while (sent_items < directed_items + (phase + 1) * quota) begin
                case ($urandom_range(0, 9))
                    0, 1:    system_walk();
                    2, 3, 4: pump_walk(rand_pump());
                    5, 6:    sensor_walk();
                    7:       push_item(OP_CAL, $urandom_range(0, 3) == 0 ?
                                       rand_code(2, 7) : rand_code(0, 1),
                                       rand_pump());
                    default: noise_burst();
                endcase
                if ($urandom_range(0, 30) == 0) tx_calm = !tx_calm;
                if ($urandom_range(0, 30) == 0) rx_calm = !rx_calm;
            end
        end
        drain_block();

        $display("Covered %0d items (%0d directed) over %0d limit settings, extremes included.",
                 sent_items, directed_items, N_PHASES + 1);
        $display("Checked %0d status results; %0d failures.", chk_results, chk_errors);
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb_dosing_supervisor_fsm: PASS");
        else
            $display("tb_dosing_supervisor_fsm: FAIL");
        $finish;
    end

endmodule
